[src/bpse_pkg.sv]
// ----------------------------------------------------------------------------
// bpse_pkg
// shared types and constants of the byte pair stream expander
// ----------------------------------------------------------------------------
package bpse_pkg;

  localparam logic [7:0] MAGIC_BYTE     = 8'hC2;
  localparam logic [7:0] PAIR_CODE_MASK = 8'h80;
  localparam logic [7:0] SKIP_HIGH_MASK = 8'h7F;

  localparam int TABLE_BYTES = 256;
  localparam int TAB_AW      = $clog2(TABLE_BYTES);
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  localparam logic [1:0] STAT_DATA  = 2'd0;
  localparam logic [1:0] STAT_MAGIC = 2'd1;
  localparam logic [1:0] STAT_DEPTH = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } bpse_res_t;

  typedef struct packed {
    logic              en;
    logic [TAB_AW-1:0] base;
  } bpse_rd_t;

  typedef struct packed {
    logic              en;
    logic [TAB_AW-1:0] addr;
    logic [7:0]        data;
  } bpse_wr_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
  } bpse_pair_t;

endpackage

[src/bpse_in_if.sv]
// ----------------------------------------------------------------------------
// bpse_in_if
// compressed byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bpse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[src/bpse_out_if.sv]
// ----------------------------------------------------------------------------
// bpse_out_if
// result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bpse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

[src/bpse_table.sv]
// ----------------------------------------------------------------------------
// bpse_table
// 256-byte pair table, one write port, paired registered read,
// per-entry valid bits so unloaded entries read as zero
// ----------------------------------------------------------------------------
module bpse_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpse_pkg::bpse_wr_t   wr,
  input  bpse_pkg::bpse_rd_t   rd,
  output bpse_pkg::bpse_pair_t pair
);

  logic [7:0]                      mem [bpse_pkg::TABLE_BYTES];
  logic [bpse_pkg::TABLE_BYTES-1:0] vld_r;
  logic [7:0]                      rd0_r;
  logic [7:0]                      rd1_r;
  logic                            v0_r;
  logic                            v1_r;
  logic [bpse_pkg::TAB_AW-1:0]     addr1;

  assign addr1 = rd.base | bpse_pkg::TAB_AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd0_r <= mem[rd.base];
      rd1_r <= mem[addr1];
      v0_r  <= vld_r[rd.base];
      v1_r  <= vld_r[addr1];
    end
  end

  assign pair.left  = v0_r ? rd0_r : 8'h00;
  assign pair.right = v1_r ? rd1_r : 8'h00;

endmodule

[src/bpse_expand.sv]
// ----------------------------------------------------------------------------
// bpse_expand
// stack sequencer that expands one data byte through the pair table,
// left entry first, one leaf or one table fetch per step
// ----------------------------------------------------------------------------
module bpse_expand #(
  parameter int MAX_DEPTH = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [7:0]           start_code,
  input  logic                 out_free,
  input  bpse_pkg::bpse_pair_t pair,
  output bpse_pkg::bpse_rd_t   rd,
  output bpse_pkg::bpse_res_t  res,
  output logic                 busy
);

  localparam int LW  = $clog2(MAX_DEPTH + 1);
  localparam int SIW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [1:0] SQ_IDLE  = 2'd0;
  localparam logic [1:0] SQ_CHECK = 2'd1;
  localparam logic [1:0] SQ_FETCH = 2'd2;

  logic [1:0]                 sq_r, sq_nxt;
  logic [7:0]                 code_r, code_nxt;
  logic [LW-1:0]              lvl_r, lvl_nxt;
  logic [LW-1:0]              sp_r, sp_nxt;
  logic [bpse_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [7:0]    stk_code_r [MAX_DEPTH];
  logic [LW-1:0] stk_lvl_r  [MAX_DEPTH];

  logic          push_en;
  logic [LW-1:0] sp_dec;
  logic [LW-1:0] lvl_inc;
  logic [SIW-1:0] top_idx;
  logic          is_pair;
  logic          at_limit;

  assign sp_dec   = sp_r - LW'(1);
  assign lvl_inc  = lvl_r + LW'(1);
  assign top_idx  = sp_dec[SIW-1:0];
  assign is_pair  = (code_r & bpse_pkg::PAIR_CODE_MASK) != 8'h00;
  assign at_limit = (cnt_r == bpse_pkg::CNT_W'(bpse_pkg::MAX_RESULTS - 1))
                    && (is_pair || sp_r != '0);
  assign busy     = sq_r != SQ_IDLE;

  always_comb begin
    sq_nxt   = sq_r;
    code_nxt = code_r;
    lvl_nxt  = lvl_r;
    sp_nxt   = sp_r;
    cnt_nxt  = cnt_r;
    push_en  = 1'b0;
    rd       = '0;
    res      = '0;
    unique case (sq_r)
      SQ_IDLE: begin
        if (start) begin
          code_nxt = start_code;
          lvl_nxt  = '0;
          sp_nxt   = '0;
          cnt_nxt  = '0;
          sq_nxt   = SQ_CHECK;
        end
      end
      SQ_CHECK: begin
        priority if (at_limit || (is_pair && lvl_r >= LW'(MAX_DEPTH))) begin
          if (out_free) begin
            res.valid  = 1'b1;
            res.status = bpse_pkg::STAT_DEPTH;
            res.last   = 1'b1;
            sq_nxt     = SQ_IDLE;
          end
        end else if (is_pair) begin
          rd.en   = 1'b1;
          rd.base = {code_r[6:0], 1'b0};
          sq_nxt  = SQ_FETCH;
        end else begin
          if (out_free) begin
            res.valid  = 1'b1;
            res.data   = code_r;
            res.status = bpse_pkg::STAT_DATA;
            res.last   = sp_r == '0;
            cnt_nxt    = cnt_r + bpse_pkg::CNT_W'(1);
            if (sp_r == '0) begin
              sq_nxt = SQ_IDLE;
            end else begin
              code_nxt = stk_code_r[top_idx];
              lvl_nxt  = stk_lvl_r[top_idx];
              sp_nxt   = sp_dec;
            end
          end
        end
      end
      SQ_FETCH: begin
        push_en  = 1'b1;
        sp_nxt   = sp_r + LW'(1);
        code_nxt = pair.left;
        lvl_nxt  = lvl_inc;
        sq_nxt   = SQ_CHECK;
      end
      default: begin
        sq_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r  <= SQ_IDLE;
      lvl_r <= '0;
      sp_r  <= '0;
      cnt_r <= '0;
    end else begin
      sq_r  <= sq_nxt;
      lvl_r <= lvl_nxt;
      sp_r  <= sp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    if (push_en) begin
      stk_code_r[sp_r[SIW-1:0]] <= pair.right;
      stk_lvl_r[sp_r[SIW-1:0]]  <= lvl_inc;
    end
  end

endmodule

[src/byte_pair_stream_expander.sv]
// ----------------------------------------------------------------------------
// byte_pair_stream_expander
// byte pair compressed stream decoder: header parse, table load, expansion
// ----------------------------------------------------------------------------
// Header, filler and table bytes are taken one per cycle. A data byte is
// accepted, then expanded left entry first: each emitted byte waits for a
// free output register, and each pair code takes a table read, then a
// stack push. The expansion runs through the pair table read port and the
// single stack sequencer; the next input byte is taken once the last result
// of the current one sits in the output register and that register is free
// or being read. A bad magic byte gives one error result, after which input
// is drained and ignored until reset. The table is cleared at reset through
// per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
module byte_pair_stream_expander #(
  parameter int MAX_DEPTH = 6
) (
  input logic       clk,
  input logic       rst_n,
  bpse_in_if.sink   in_ch,
  bpse_out_if.source out_ch
);

  localparam logic [2:0] PH_MAGIC      = 3'd0;
  localparam logic [2:0] PH_SKIP_LEN   = 3'd1;
  localparam logic [2:0] PH_SKIP_LOW   = 3'd2;
  localparam logic [2:0] PH_SKIPPING   = 3'd3;
  localparam logic [2:0] PH_TABLE_LEN  = 3'd4;
  localparam logic [2:0] PH_TABLE_DATA = 3'd5;
  localparam logic [2:0] PH_DATA       = 3'd6;
  localparam logic [2:0] PH_DEAD       = 3'd7;

  logic [2:0]  phase_r, phase_nxt;
  logic [6:0]  skip_high_r, skip_high_nxt;
  logic [14:0] skip_rem_r, skip_rem_nxt;
  logic [8:0]  tab_rem_r, tab_rem_nxt;
  logic [8:0]  tab_idx_r, tab_idx_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [1:0]  out_status_r;
  logic        out_last_r;

  logic        out_free;
  logic        in_acc;
  logic        magic_err;
  logic        ex_start;
  logic        ex_busy;
  logic [14:0] skip_dec;
  logic [8:0]  tab_dec;
  logic [14:0] skip_full;
  logic [8:0]  tab_len;

  bpse_pkg::bpse_wr_t   tab_wr;
  bpse_pkg::bpse_rd_t   tab_rd;
  bpse_pkg::bpse_pair_t tab_pair;
  bpse_pkg::bpse_res_t  ex_res;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !ex_busy && out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign skip_dec     = (skip_rem_r != '0) ? skip_rem_r - 15'd1 : 15'd0;
  assign tab_dec      = (tab_rem_r != '0) ? tab_rem_r - 9'd1 : 9'd0;
  assign skip_full    = {skip_high_r, in_ch.in_byte};
  assign tab_len      = {in_ch.in_byte, 1'b0};
  assign ex_start     = in_acc && phase_r == PH_DATA;

  always_comb begin
    phase_nxt     = phase_r;
    skip_high_nxt = skip_high_r;
    skip_rem_nxt  = skip_rem_r;
    tab_rem_nxt   = tab_rem_r;
    tab_idx_nxt   = tab_idx_r;
    magic_err     = 1'b0;
    tab_wr        = '0;
    if (in_acc) begin
      unique case (phase_r)
        PH_MAGIC: begin
          if (in_ch.in_byte != bpse_pkg::MAGIC_BYTE) begin
            magic_err = 1'b1;
            phase_nxt = PH_DEAD;
          end else begin
            phase_nxt = PH_SKIP_LEN;
          end
        end
        PH_SKIP_LEN: begin
          priority if (in_ch.in_byte == 8'h00) begin
            phase_nxt = PH_TABLE_LEN;
          end else if ((in_ch.in_byte & bpse_pkg::PAIR_CODE_MASK) != 8'h00) begin
            skip_high_nxt = 7'(in_ch.in_byte & bpse_pkg::SKIP_HIGH_MASK);
            phase_nxt     = PH_SKIP_LOW;
          end else begin
            skip_rem_nxt = {7'd0, in_ch.in_byte};
            phase_nxt    = PH_SKIPPING;
          end
        end
        PH_SKIP_LOW: begin
          skip_rem_nxt = skip_full;
          phase_nxt    = (skip_full == '0) ? PH_SKIP_LEN : PH_SKIPPING;
        end
        PH_SKIPPING: begin
          skip_rem_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = PH_SKIP_LEN;
          end
        end
        PH_TABLE_LEN: begin
          tab_rem_nxt = tab_len;
          tab_idx_nxt = '0;
          phase_nxt   = (tab_len == '0) ? PH_DATA : PH_TABLE_DATA;
        end
        PH_TABLE_DATA: begin
          tab_wr.en   = !tab_idx_r[8];
          tab_wr.addr = tab_idx_r[7:0];
          tab_wr.data = in_ch.in_byte;
          tab_idx_nxt = tab_idx_r + 9'd1;
          tab_rem_nxt = tab_dec;
          if (tab_dec == '0) begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
        end
        PH_DEAD: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC;
      skip_high_r <= '0;
      skip_rem_r  <= '0;
      tab_rem_r   <= '0;
      tab_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      skip_high_r <= skip_high_nxt;
      skip_rem_r  <= skip_rem_nxt;
      tab_rem_r   <= tab_rem_nxt;
      tab_idx_r   <= tab_idx_nxt;
      if (out_free) begin
        out_valid_r <= ex_res.valid || magic_err;
      end
    end
  end

  // output register, loaded from the expander or the bad magic path
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (magic_err) begin
        out_byte_r   <= 8'h00;
        out_status_r <= bpse_pkg::STAT_MAGIC;
        out_last_r   <= 1'b1;
      end else begin
        out_byte_r   <= ex_res.data;
        out_status_r <= ex_res.status;
        out_last_r   <= ex_res.last;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.last     = out_last_r;

  bpse_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (tab_wr),
    .rd    (tab_rd),
    .pair  (tab_pair)
  );

  bpse_expand #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_expand (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (ex_start),
    .start_code (in_ch.in_byte),
    .out_free   (out_free),
    .pair       (tab_pair),
    .rd         (tab_rd),
    .res        (ex_res),
    .busy       (ex_busy)
  );

  a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != bpse_pkg::STAT_DATA
      |-> out_ch.last && out_ch.out_byte == 8'h00)
    else $error("error result with data or without last");

  a_magic_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == bpse_pkg::STAT_MAGIC |-> phase_r == PH_DEAD)
    else $error("bad magic result outside dead phase");

  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ex_busy) |-> $past(in_acc) && $past(phase_r) == PH_DATA)
    else $error("expansion started without a data beat");

  a_dead_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DEAD |-> !ex_busy)
    else $error("expander busy after bad magic");

endmodule
